### rtl/sdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the framed receive deframer
// Byte codes of the framing, result kinds, verdict reasons and the result
// record that travels from the frame logic to the output register.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Default longest frame, in bytes, before the length counter wraps.
  localparam int unsigned MAX_FRAME_DEF = 2048;

  // Framing bytes.
  localparam logic [7:0] DELIM = 8'h7E;
  localparam logic [7:0] ESC   = 8'h7D;

  // Escaped codes and what they stand for.
  localparam logic [7:0] ESC_XON_CODE    = 8'h31;
  localparam logic [7:0] ESC_XON_VALUE   = 8'h11;
  localparam logic [7:0] ESC_XOFF_CODE   = 8'h33;
  localparam logic [7:0] ESC_XOFF_VALUE  = 8'h13;
  localparam logic [7:0] ESC_ESC_CODE    = 8'h5D;
  localparam logic [7:0] ESC_DELIM_CODE  = 8'h5E;

  // Result kinds.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict reasons, in the order they are checked.
  localparam logic [1:0] REASON_OK    = 2'd0;
  localparam logic [1:0] REASON_STATE = 2'd1;
  localparam logic [1:0] REASON_START = 2'd2;
  localparam logic [1:0] REASON_SUM   = 2'd3;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_value;
    logic [10:0] byte_index;
    logic        frame_ok;
    logic [1:0]  fail_reason;
    logic [7:0]  frame_command;
    logic [11:0] frame_length;
    logic [7:0]  received_checksum;
    logic [7:0]  computed_checksum;
  } sdf_result_t;

endpackage

### rtl/shdlc_rx_deframer.sv
`timescale 1ns / 1ps
// A result item passes from the input register through the frame logic into
// the result register, and waits in either while the result side stalls.
// Throughput: one byte per cycle while results are taken; a waiting result
// stalls the frame logic, and in_ready drops once the input register is full.
// An escape byte is consumed without a result.
// Reset: synchronous, active low; clears the frame state and both valid flags.
// ----------------------------------------------------------------------------
// shdlc_rx_deframer: receive deframer for delimited serial frames
// Removes escapes, emits every stored byte with its index and a verdict on
// the state byte, start delimiter and checksum at each closing delimiter.
// ----------------------------------------------------------------------------
module shdlc_rx_deframer #(
  parameter int unsigned MAX_FRAME = sdf_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte_value,
  output logic [10:0] out_byte_index,
  output logic        out_frame_ok,
  output logic [1:0]  out_fail_reason,
  output logic [7:0]  out_frame_command,
  output logic [11:0] out_frame_length,
  output logic [7:0]  out_received_checksum,
  output logic [7:0]  out_computed_checksum
);

  logic                 hold_valid;
  logic [7:0]           hold_byte;
  logic                 fire;
  logic                 can_load;
  logic                 res_valid;
  sdf_pkg::sdf_result_t res;
  sdf_pkg::sdf_result_t out_res;

  // A held byte is processed when the result register has room.
  assign fire = hold_valid && can_load;

  sdf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (fire)
  );

  sdf_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (hold_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sdf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_res  (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Result fields onto their ports.
  assign out_kind              = out_res.kind;
  assign out_byte_value        = out_res.byte_value;
  assign out_byte_index        = out_res.byte_index;
  assign out_frame_ok          = out_res.frame_ok;
  assign out_fail_reason       = out_res.fail_reason;
  assign out_frame_command     = out_res.frame_command;
  assign out_frame_length      = out_res.frame_length;
  assign out_received_checksum = out_res.received_checksum;
  assign out_computed_checksum = out_res.computed_checksum;

endmodule

### rtl/sdf_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_in_reg: input register of the deframer
// Holds one received byte until the frame logic takes it; takes a new item
// in the same cycle that the held one moves on.
// ----------------------------------------------------------------------------
module sdf_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       hold_valid,
  output logic [7:0] hold_byte,
  input  logic       take
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // The register is free when empty or when its item leaves this cycle.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

### rtl/sdf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_core: frame state and per-byte decoding
// Undoes escapes, tracks length, key bytes and the running sum, and forms
// either a stored-byte item or an end-of-frame verdict for each non-escape byte taken.
// ----------------------------------------------------------------------------
module sdf_core #(
  parameter int unsigned MAX_FRAME = sdf_pkg::MAX_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output sdf_pkg::sdf_result_t res
);

  localparam int unsigned HW = $clog2(MAX_FRAME);
  localparam logic [HW-1:0] LAST_INDEX = HW'(MAX_FRAME - 1);
  localparam logic [HW-1:0] SHORT_LIMIT = HW'(4);

  logic [HW-1:0] held_r, held_nxt;
  logic          esc_r, esc_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    dev_state_r, dev_state_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [7:0]    sum_r, sum_nxt;

  logic [7:0]    plain_byte;
  logic [7:0]    calc_sum;
  logic [1:0]    reason;

  // Translate an escaped byte.
  always_comb begin
    plain_byte = rx_byte;
    if (esc_r) begin
      case (rx_byte)
        sdf_pkg::ESC_XON_CODE:   plain_byte = sdf_pkg::ESC_XON_VALUE;
        sdf_pkg::ESC_XOFF_CODE:  plain_byte = sdf_pkg::ESC_XOFF_VALUE;
        sdf_pkg::ESC_ESC_CODE:   plain_byte = sdf_pkg::ESC;
        sdf_pkg::ESC_DELIM_CODE: plain_byte = sdf_pkg::DELIM;
        default:                 plain_byte = rx_byte;
      endcase
    end
  end

  // The sum holds bytes up to the checksum; take the checksum back out.
  assign calc_sum = ~(sum_r - prev_r);

  // First failing check wins.
  always_comb begin
    if (dev_state_r != 8'h00) begin
      reason = sdf_pkg::REASON_STATE;
    end else if (first_r != sdf_pkg::DELIM) begin
      reason = sdf_pkg::REASON_START;
    end else if (calc_sum != prev_r) begin
      reason = sdf_pkg::REASON_SUM;
    end else begin
      reason = sdf_pkg::REASON_OK;
    end
  end

  // Next state and result of the byte being taken.
  always_comb begin
    held_nxt      = held_r;
    esc_nxt       = esc_r;
    first_nxt     = first_r;
    cmd_nxt       = cmd_r;
    dev_state_nxt = dev_state_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    res_valid     = 1'b0;
    res           = '0;
    if (fire) begin
      if (rx_byte == sdf_pkg::DELIM) begin
        esc_nxt = 1'b0;
        if (held_r > SHORT_LIMIT) begin
          // Closing delimiter: emit the verdict and start over.
          res_valid             = 1'b1;
          res.kind              = sdf_pkg::KIND_VERDICT;
          res.byte_value        = sdf_pkg::DELIM;
          res.byte_index        = 11'(held_r);
          res.frame_ok          = (reason == sdf_pkg::REASON_OK);
          res.fail_reason       = reason;
          res.frame_command     = cmd_r;
          res.frame_length      = 12'({1'b0, held_r} + {{HW{1'b0}}, 1'b1});
          res.received_checksum = prev_r;
          res.computed_checksum = calc_sum;
          held_nxt              = '0;
        end else begin
          // Too short to be a frame: restart with this delimiter at index 0.
          res_valid      = 1'b1;
          res.kind       = sdf_pkg::KIND_BYTE;
          res.byte_value = sdf_pkg::DELIM;
          res.byte_index = '0;
          first_nxt      = sdf_pkg::DELIM;
          sum_nxt        = 8'h00;
          prev_nxt       = sdf_pkg::DELIM;
          held_nxt       = HW'(1);
        end
      end else if (rx_byte == sdf_pkg::ESC) begin
        esc_nxt = 1'b1;
      end else begin
        // Ordinary byte: store it at the current index.
        esc_nxt        = 1'b0;
        res_valid      = 1'b1;
        res.kind       = sdf_pkg::KIND_BYTE;
        res.byte_value = plain_byte;
        res.byte_index = 11'(held_r);
        if (held_r == '0) begin
          first_nxt = plain_byte;
          sum_nxt   = 8'h00;
        end else begin
          sum_nxt = sum_r + plain_byte;
        end
        if (held_r == HW'(2)) begin
          cmd_nxt = plain_byte;
        end
        if (held_r == HW'(3)) begin
          dev_state_nxt = plain_byte;
        end
        prev_nxt = plain_byte;
        if (held_r == LAST_INDEX) begin
          held_nxt = '0;
        end else begin
          held_nxt = held_r + HW'(1);
        end
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      esc_r       <= 1'b0;
      first_r     <= 8'h00;
      cmd_r       <= 8'h00;
      dev_state_r <= 8'h00;
      prev_r      <= 8'h00;
      sum_r       <= 8'h00;
    end else begin
      held_r      <= held_nxt;
      esc_r       <= esc_nxt;
      first_r     <= first_nxt;
      cmd_r       <= cmd_nxt;
      dev_state_r <= dev_state_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
    end
  end

`ifndef SYNTH
  // An escape byte is consumed silently and leaves an escape pending.
  a_esc_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && rx_byte == sdf_pkg::ESC |-> !res_valid ##1 esc_r)
    else $error("escape byte produced an item or was lost");

  // A delimiter always clears a pending escape.
  a_delim_clears_esc: assert property (@(posedge clk) disable iff (!rst_n)
    fire && rx_byte == sdf_pkg::DELIM |=> !esc_r)
    else $error("escape pending after delimiter");

  // A verdict always leaves an empty frame.
  a_verdict_empties: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == sdf_pkg::KIND_VERDICT |=> held_r == '0)
    else $error("frame length not cleared after verdict");

  // A restart delimiter leaves exactly one byte held.
  a_restart_one: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == sdf_pkg::KIND_BYTE && res.byte_value == sdf_pkg::DELIM
    && !esc_r && rx_byte == sdf_pkg::DELIM |=> held_r == HW'(1) && first_r == sdf_pkg::DELIM)
    else $error("restart did not start a new frame");
`endif

endmodule

### rtl/sdf_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_out_reg: result register of the deframer
// Holds one result item for the receiver; loads a new one when empty or
// when the held item is taken in the same cycle.
// ----------------------------------------------------------------------------
module sdf_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sdf_pkg::sdf_result_t load_res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdf_pkg::sdf_result_t out_res
);

  logic                 valid_r;
  logic                 valid_nxt;
  sdf_pkg::sdf_result_t res_r;

  // Room when empty or when the held item leaves this cycle.
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the delimited frame receive deframer
// Feeds raw serial bytes through a valid/ready channel and checks every
// stored byte and every end-of-frame verdict against a built-in model of the
// deframer. A short table of hand-picked bytes comes first. Random frames,
// noise and broken frames follow.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned FRAME_LIMIT = sdf_pkg::MAX_FRAME_DEF;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_byte_value;
  logic [10:0] out_byte_index;
  logic        out_frame_ok;
  logic [1:0]  out_fail_reason;
  logic [7:0]  out_frame_command;
  logic [11:0] out_frame_length;
  logic [7:0]  out_received_checksum;
  logic [7:0]  out_computed_checksum;

  // One row of the hand-written byte sequence.
  typedef struct {
    logic [7:0]           rx;
    bit                   typed;
    sdf_pkg::sdf_result_t want;
  } byte_row_t;

  // Results still owed by the deframer, oldest first.
  sdf_pkg::sdf_result_t results_due[$];
  byte_row_t            byte_rows[$];

  // Model copy of the frame state.
  int unsigned pr_held;
  bit          pr_escape;
  logic [7:0]  pr_first;
  logic [7:0]  pr_command;
  logic [7:0]  pr_state;
  logic [7:0]  pr_last;
  logic [7:0]  pr_sum;

  int fail_count;
  int bytes_taken;
  int results_caused;
  int results_checked;
  int verdicts_checked;
  int rx_hold_cycles;
  bit tx_jitter;

  shdlc_rx_deframer i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_byte_value        (out_byte_value),
    .out_byte_index        (out_byte_index),
    .out_frame_ok          (out_frame_ok),
    .out_fail_reason       (out_fail_reason),
    .out_frame_command     (out_frame_command),
    .out_frame_length      (out_frame_length),
    .out_received_checksum (out_received_checksum),
    .out_computed_checksum (out_computed_checksum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #15_000_000;
    $display("status: fail");
    $finish;
  end

  // Model of one accepted byte; returns 1 when the byte yields a result item.
  function automatic bit deframe_predict(input logic [7:0] rx,
                                         output sdf_pkg::sdf_result_t r);
    logic [7:0] b;
    logic [7:0] calc;
    logic [1:0] why;
    b = rx;
    r = '0;
    if (b == sdf_pkg::DELIM) begin
      pr_escape = 1'b0;
      // A delimiter after more than four bytes closes the frame.
      if (pr_held > 4) begin
        calc = ~(pr_sum - pr_last);
        if (pr_state != 8'h00) why = sdf_pkg::REASON_STATE;
        else if (pr_first != sdf_pkg::DELIM) why = sdf_pkg::REASON_START;
        else if (calc != pr_last) why = sdf_pkg::REASON_SUM;
        else why = sdf_pkg::REASON_OK;
        r.kind              = sdf_pkg::KIND_VERDICT;
        r.byte_value        = sdf_pkg::DELIM;
        r.byte_index        = 11'(pr_held);
        r.frame_ok          = (why == sdf_pkg::REASON_OK);
        r.fail_reason       = why;
        r.frame_command     = pr_command;
        r.frame_length      = 12'(pr_held + 1);
        r.received_checksum = pr_last;
        r.computed_checksum = calc;
        pr_held = 0;
        return 1'b1;
      end
      // Otherwise the frame restarts with this delimiter at index zero.
      pr_held = 0;
    end else if (b == sdf_pkg::ESC) begin
      pr_escape = 1'b1;
      return 1'b0;
    end else begin
      if (pr_escape) begin
        case (b)
          sdf_pkg::ESC_XON_CODE:   b = sdf_pkg::ESC_XON_VALUE;
          sdf_pkg::ESC_XOFF_CODE:  b = sdf_pkg::ESC_XOFF_VALUE;
          sdf_pkg::ESC_ESC_CODE:   b = sdf_pkg::ESC;
          sdf_pkg::ESC_DELIM_CODE: b = sdf_pkg::DELIM;
          default: ;
        endcase
      end
      pr_escape = 1'b0;
    end
    // Store the byte at the current index.
    if (pr_held == 0) begin
      pr_first = b;
      pr_sum   = 8'h00;
    end else begin
      pr_sum = pr_sum + b;
    end
    if (pr_held == 2) pr_command = b;
    if (pr_held == 3) pr_state = b;
    pr_last      = b;
    r.kind       = sdf_pkg::KIND_BYTE;
    r.byte_value = b;
    r.byte_index = 11'(pr_held);
    pr_held++;
    if (pr_held > FRAME_LIMIT - 1) pr_held = 0;
    return 1'b1;
  endfunction

  function automatic sdf_pkg::sdf_result_t stored_item(input logic [7:0] v,
                                                       input logic [10:0] idx);
    sdf_pkg::sdf_result_t r;
    r            = '0;
    r.kind       = sdf_pkg::KIND_BYTE;
    r.byte_value = v;
    r.byte_index = idx;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Any byte except the delimiter and the escape.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == sdf_pkg::DELIM || b == sdf_pkg::ESC);
    return b;
  endfunction

  function automatic void compare_field(input string fname, input logic [11:0] want,
                                        input logic [11:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", fname, want, got);
      fail_count++;
    end
  endfunction

  task automatic add_row(input logic [7:0] rx, input bit typed = 1'b0,
                         input sdf_pkg::sdf_result_t want = '0);
    byte_row_t row;
    row.rx    = rx;
    row.typed = typed;
    row.want  = want;
    byte_rows.push_back(row);
  endtask

  // Offer one byte, wait for it to be taken and record what it should yield.
  task automatic send_raw(input logic [7:0] b, input bit typed = 1'b0,
                          input sdf_pkg::sdf_result_t want = '0);
    sdf_pkg::sdf_result_t r;
    bit                   yields;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    yields = deframe_predict(b, r);
    if (yields || typed) begin
      results_due.push_back(typed ? want : r);
      results_caused++;
    end
    bytes_taken++;
    if (tx_jitter && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Send a payload byte, escaping delimiters and escapes always and XON or XOFF at random.
  task automatic send_stuffed(input logic [7:0] b);
    if (b == sdf_pkg::DELIM) begin
      send_raw(sdf_pkg::ESC);
      send_raw(sdf_pkg::ESC_DELIM_CODE);
    end else if (b == sdf_pkg::ESC) begin
      send_raw(sdf_pkg::ESC);
      send_raw(sdf_pkg::ESC_ESC_CODE);
    end else if (b == sdf_pkg::ESC_XON_VALUE && $urandom_range(0, 1)) begin
      send_raw(sdf_pkg::ESC);
      send_raw(sdf_pkg::ESC_XON_CODE);
    end else if (b == sdf_pkg::ESC_XOFF_VALUE && $urandom_range(0, 1)) begin
      send_raw(sdf_pkg::ESC);
      send_raw(sdf_pkg::ESC_XOFF_CODE);
    end else begin
      send_raw(b);
    end
  endtask

  // A complete frame with random content, now and then with a flaw.
  task automatic send_frame();
    logic [7:0] body[$];
    logic [7:0] cs;
    logic [7:0] b;
    int         n;
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
    n = $urandom_range(0, 8);
    body.push_back(8'(n));
    for (int i = 0; i < n; i++) begin
      // Bias the data toward the bytes that need escaping.
      case ($urandom_range(0, 9))
        0: b = sdf_pkg::DELIM;
        1: b = sdf_pkg::ESC;
        2: b = ($urandom_range(0, 1)) ? sdf_pkg::ESC_XON_VALUE : sdf_pkg::ESC_XOFF_VALUE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      body.push_back(b);
    end
    cs = 8'h00;
    foreach (body[i]) cs = cs + body[i];
    cs = ~cs;
    if ($urandom_range(0, 9) == 0) cs = cs ^ 8'($urandom_range(1, 255));
    send_raw(($urandom_range(0, 19) == 0) ? plain_byte() : sdf_pkg::DELIM);
    foreach (body[i]) send_stuffed(body[i]);
    send_stuffed(cs);
    send_raw(sdf_pkg::DELIM);
  endtask

  // Stop sending and wait for every owed result, up to a cycle limit.
  task automatic drain_results(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (results_due.size() != 0 && waited < limit);
  endtask

  // Result side: random stalls, calm stretches and the requested long hold-off.
  initial begin : rx_side
    int gap;
    int cyc;
    gap = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        rx_hold_cycles--;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
        if (((cyc / 200) % 4) != 3 && $urandom_range(0, 99) < 20) gap = pick_gap();
      end
    end
  end

  // Check each taken result against the oldest owed one.
  always @(posedge clk) begin
    sdf_pkg::sdf_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result item with none owed: kind %0d value %0h index %0d",
               out_kind, out_byte_value, out_byte_index);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        compare_field("kind", 12'(want.kind), 12'(out_kind));
        compare_field("byte_value", 12'(want.byte_value), 12'(out_byte_value));
        compare_field("byte_index", 12'(want.byte_index), 12'(out_byte_index));
        compare_field("frame_ok", 12'(want.frame_ok), 12'(out_frame_ok));
        compare_field("fail_reason", 12'(want.fail_reason), 12'(out_fail_reason));
        compare_field("frame_command", 12'(want.frame_command),
                      12'(out_frame_command));
        compare_field("frame_length", want.frame_length, out_frame_length);
        compare_field("received_checksum", 12'(want.received_checksum),
                      12'(out_received_checksum));
        compare_field("computed_checksum", 12'(want.computed_checksum),
                      12'(out_computed_checksum));
        results_checked++;
        if (want.kind == sdf_pkg::KIND_VERDICT) verdicts_checked++;
      end
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    sdf_pkg::sdf_result_t v;
    int                   base;
    bit                   paused;
    bit                   held_off;
    fail_count       = 0;
    bytes_taken      = 0;
    results_caused   = 0;
    results_checked  = 0;
    verdicts_checked = 0;
    rx_hold_cycles   = 0;
    tx_jitter        = 1'b1;
    pr_held    = 0;
    pr_escape  = 1'b0;
    pr_first   = 8'h00;
    pr_command = 8'h00;
    pr_state   = 8'h00;
    pr_last    = 8'h00;
    pr_sum     = 8'h00;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frame without a leading delimiter, with a doubled escape and escaped codes.
    add_row(8'hFF, 1'b1, stored_item(8'hFF, 11'd0));
    add_row(sdf_pkg::ESC);
    add_row(sdf_pkg::ESC);
    add_row(sdf_pkg::ESC_XOFF_CODE, 1'b1, stored_item(sdf_pkg::ESC_XOFF_VALUE, 11'd1));
    add_row(sdf_pkg::ESC);
    add_row(sdf_pkg::ESC_ESC_CODE, 1'b1, stored_item(sdf_pkg::ESC, 11'd2));
    add_row(8'h00, 1'b1, stored_item(8'h00, 11'd3));
    add_row(8'h00, 1'b1, stored_item(8'h00, 11'd4));
    v                   = '0;
    v.kind              = sdf_pkg::KIND_VERDICT;
    v.byte_value        = sdf_pkg::DELIM;
    v.byte_index        = 11'd5;
    v.fail_reason       = sdf_pkg::REASON_START;
    v.frame_command     = sdf_pkg::ESC;
    v.frame_length      = 12'd6;
    v.received_checksum = 8'h00;
    v.computed_checksum = 8'h6F;
    add_row(sdf_pkg::DELIM, 1'b1, v);
    // An escape right before a delimiter is dropped; the delimiter restarts.
    add_row(sdf_pkg::ESC);
    add_row(sdf_pkg::DELIM, 1'b1, stored_item(sdf_pkg::DELIM, 11'd0));
    // A good frame carrying an escaped delimiter and an escaped XON.
    add_row(8'h00);
    add_row(8'h03);
    add_row(8'h00);
    add_row(sdf_pkg::ESC);
    add_row(sdf_pkg::ESC_DELIM_CODE);
    add_row(sdf_pkg::ESC);
    add_row(sdf_pkg::ESC_XON_CODE);
    add_row(8'h6D);
    add_row(sdf_pkg::DELIM);
    // After a verdict a delimiter opens the next frame, whose state byte is set.
    add_row(sdf_pkg::DELIM, 1'b1, stored_item(sdf_pkg::DELIM, 11'd0));
    add_row(8'h00);
    add_row(8'h01);
    add_row(8'h05);
    add_row(8'hFF);
    v.byte_index        = 11'd5;
    v.fail_reason       = sdf_pkg::REASON_STATE;
    v.frame_command     = 8'h01;
    v.frame_length      = 12'd6;
    v.received_checksum = 8'hFF;
    v.computed_checksum = 8'hF9;
    add_row(sdf_pkg::DELIM, 1'b1, v);
    foreach (byte_rows[i]) send_raw(byte_rows[i].rx, byte_rows[i].typed, byte_rows[i].want);

    // Random part: mostly well-formed frames, some noise and broken frames.
    base     = bytes_taken;
    paused   = 1'b0;
    held_off = 1'b0;
    while (bytes_taken < base + 410) begin
      tx_jitter = (((bytes_taken - base) / 64) % 4) != 3;
      if (!paused && bytes_taken > base + 140) begin
        drain_results(100000);
        paused = 1'b1;
      end
      if (!held_off && bytes_taken > base + 270) begin
        // The result side stalls while whole frames keep coming.
        rx_hold_cycles = 300;
        held_off       = 1'b1;
        send_frame();
        send_frame();
      end
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(1, 6)) send_raw(8'($urandom_range(0, 255)));
        end
        8: begin
          send_raw(sdf_pkg::DELIM);
          repeat ($urandom_range(0, 6)) send_raw(plain_byte());
          send_raw(sdf_pkg::DELIM);
        end
        9: begin
          if ($urandom_range(0, 1)) send_raw(sdf_pkg::ESC);
          send_raw(sdf_pkg::DELIM);
        end
        default: send_frame();
      endcase
    end

    drain_results(20000);
    repeat (10) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d result items never arrived", results_due.size());
      fail_count += results_due.size();
    end

    $display("Run covered %0d bytes taken, %0d result items owed and %0d checked, %0d verdicts,",
             bytes_taken, results_caused, results_checked, verdicts_checked);
    $display("with escapes, short restarts, stalls on both sides and a full drain; %0d failures.",
             fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
